>>> rtl/core/gobu_pkg.sv
// Shared types, constants and helpers of the gradient orientation binner.
`timescale 1ns / 1ps
package gobu_pkg;

   // Square root chain: one result bit per cell, radicand holds dx^2 + dy^2
   localparam int unsigned ROOT_STEPS = 32;
   localparam int unsigned RAD_W      = 2 * ROOT_STEPS - 1;

   // Reset value of the scale register: 1.0 in unsigned Q8.24
   localparam logic [31:0] INV_SCALE_RESET = 32'd16777216;

   // Rounding constant for the Q28 to Q16 reduction of a scaled difference
   localparam logic [11:0] ROUND_HALF = 12'd2048;

   // Epsilon added to dx: 0.0001 in Q15.16
   localparam logic signed [46:0] EPS_Q16 = 47'sd7;

   // Symmetric saturation bounds of a Q15.16 component
   localparam logic signed [46:0] SAT_HI  = 47'sd2147483647;
   localparam logic signed [46:0] SAT_LO  = -47'sd2147483647;
   localparam logic signed [31:0] SAT_POS = 32'sd2147483647;
   localparam logic signed [31:0] SAT_NEG = -32'sd2147483647;

   // Sector thresholds tan(22.5 deg) and tan(67.5 deg) in Q4.28
   localparam logic [26:0] T1_Q28 = 27'd111189606;
   localparam logic [29:0] T3_Q28 = 30'd648060518;

   // Bin codes
   localparam logic [2:0] BIN_OFFSET   = 3'd4;
   localparam logic [2:0] BIN_VERTICAL = 3'd4;
   localparam logic [2:0] BIN_BORDER   = 3'd0;
   localparam logic [2:0] BIN_FLAT     = 3'd3;

   // One pixel neighbourhood as it enters the datapath
   typedef struct packed {
      logic [23:0] pixel_above;
      logic [23:0] pixel_below;
      logic [23:0] pixel_left;
      logic [23:0] pixel_right;
      logic        on_border;
   } gobu_pix_type;

   // Item moving along the square root chain
   typedef struct packed {
      logic [RAD_W-1:0] rem;
      logic [RAD_W-1:0] res;
      logic [2:0]       bin;
      logic             clip;
   } gobu_root_type;

   // Saturate a wide signed value to Q15.16; top bit of the result is the clip flag
   function automatic logic [32:0] sat_q16(input logic signed [46:0] v);
      logic [32:0] r;
      if (v > SAT_HI) begin
         r = {1'b1, SAT_HI[31:0]};
      end else if (v < SAT_LO) begin
         r = {1'b1, SAT_LO[31:0]};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

endpackage

>>> rtl/core/gobu_if.sv
// Request and response channel interfaces of the gradient orientation binner.
`timescale 1ns / 1ps
interface gobu_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] pixel_above;
   logic [23:0] pixel_below;
   logic [23:0] pixel_left;
   logic [23:0] pixel_right;
   logic        on_border;

   modport source (output valid, output pixel_above, output pixel_below,
                   output pixel_left, output pixel_right, output on_border,
                   input ready);
   modport sink   (input valid, input pixel_above, input pixel_below,
                   input pixel_left, input pixel_right, input on_border,
                   output ready);
endinterface

interface gobu_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  orientation_bin;
   logic [31:0] magnitude;
   logic        clipped;

   modport source (output valid, output orientation_bin, output magnitude,
                   output clipped, input ready);
   modport sink   (input valid, input orientation_bin, input magnitude,
                   input clipped, output ready);
endinterface

>>> rtl/core/gobu_front.sv
// Gradient front end: scaling, saturation, sector compares and radicand.
`timescale 1ns / 1ps
module gobu_front import gobu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic [31:0]   inv_scale,
   input  logic          up_valid,
   output logic          up_ready,
   input  gobu_pix_type  up_data,
   output logic          dn_valid,
   input  logic          dn_ready,
   output gobu_root_type dn_data
);

   localparam int unsigned NSTG = 6;

   logic [NSTG-1:0] vld_ff, vld_in, feed;
   logic [NSTG:0]   adv;

   // Advance a stage when it is empty or its successor advances
   always_comb begin
      adv[NSTG] = dn_ready;
      for (int i = NSTG - 1; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   assign feed     = {vld_ff[NSTG-2:0], up_valid};
   assign vld_in   = (adv[NSTG-1:0] & feed) | (~adv[NSTG-1:0] & vld_ff);
   assign up_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Stage 0: neighbour differences as sign and magnitude
   logic [24:0] diff_y, diff_x;
   logic [23:0] s0_ymag_ff, s0_xmag_ff, s0_ymag_in, s0_xmag_in;
   logic        s0_yneg_ff, s0_xneg_ff, s0_bord_ff;

   always_comb begin
      diff_y     = {1'b0, up_data.pixel_below} - {1'b0, up_data.pixel_above};
      diff_x     = {1'b0, up_data.pixel_right} - {1'b0, up_data.pixel_left};
      s0_ymag_in = diff_y[24] ? 24'(-diff_y) : diff_y[23:0];
      s0_xmag_in = diff_x[24] ? 24'(-diff_x) : diff_x[23:0];
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s0_ymag_ff <= s0_ymag_in;
         s0_xmag_ff <= s0_xmag_in;
         s0_yneg_ff <= diff_y[24];
         s0_xneg_ff <= diff_x[24];
         s0_bord_ff <= up_data.on_border;
      end
   end

   // Stage 1: multiply magnitudes by the scale
   logic [55:0] s1_yprod_ff, s1_xprod_ff;
   logic        s1_yneg_ff, s1_xneg_ff, s1_bord_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_yprod_ff <= 56'(s0_ymag_ff) * 56'(inv_scale);
         s1_xprod_ff <= 56'(s0_xmag_ff) * 56'(inv_scale);
         s1_yneg_ff  <= s0_yneg_ff;
         s1_xneg_ff  <= s0_xneg_ff;
         s1_bord_ff  <= s0_bord_ff;
      end
   end

   // Stage 2: round to Q16, restore sign, add epsilon, saturate
   logic [56:0]        yrnd, xrnd;
   logic signed [46:0] ymag_s, xmag_s, yval, xval;
   logic [32:0]        ysat, xsat;
   logic signed [31:0] s2_dy_ff, s2_dx_ff;
   logic               s2_clip_ff, s2_bord_ff;

   always_comb begin
      yrnd   = {1'b0, s1_yprod_ff} + 57'(ROUND_HALF);
      xrnd   = {1'b0, s1_xprod_ff} + 57'(ROUND_HALF);
      ymag_s = signed'({2'b00, yrnd[56:12]});
      xmag_s = signed'({2'b00, xrnd[56:12]});
      yval   = s1_yneg_ff ? -ymag_s : ymag_s;
      xval   = (s1_xneg_ff ? -xmag_s : xmag_s) + EPS_Q16;
      ysat   = sat_q16(yval);
      xsat   = sat_q16(xval);
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_dy_ff   <= signed'(ysat[31:0]);
         s2_dx_ff   <= signed'(xsat[31:0]);
         s2_clip_ff <= ysat[32] | xsat[32];
         s2_bord_ff <= s1_bord_ff;
      end
   end

   // Stage 3: fold into the right half plane, take magnitudes
   logic [30:0]        s3_ax_ff, s3_sy_ff;
   logic signed [31:0] s3_ay_ff;
   logic               s3_clip_ff, s3_bord_ff;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_ax_ff   <= s2_dx_ff[31] ? 31'(-s2_dx_ff) : s2_dx_ff[30:0];
         s3_ay_ff   <= s2_dx_ff[31] ? -s2_dy_ff : s2_dy_ff;
         s3_sy_ff   <= s2_dy_ff[31] ? 31'(-s2_dy_ff) : s2_dy_ff[30:0];
         s3_clip_ff <= s2_clip_ff;
         s3_bord_ff <= s2_bord_ff;
      end
   end

   // Stage 4: threshold products and squares
   logic [57:0]        s4_e1_ff;
   logic [60:0]        s4_e3_ff;
   logic [61:0]        s4_sx2_ff, s4_sy2_ff;
   logic [30:0]        s4_ax_ff;
   logic signed [31:0] s4_ay_ff;
   logic               s4_clip_ff, s4_bord_ff;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s4_e1_ff   <= 58'(T1_Q28) * 58'(s3_ax_ff);
         s4_e3_ff   <= 61'(T3_Q28) * 61'(s3_ax_ff);
         s4_sx2_ff  <= 62'(s3_ax_ff) * 62'(s3_ax_ff);
         s4_sy2_ff  <= 62'(s3_sy_ff) * 62'(s3_sy_ff);
         s4_ax_ff   <= s3_ax_ff;
         s4_ay_ff   <= s3_ay_ff;
         s4_clip_ff <= s3_clip_ff;
         s4_bord_ff <= s3_bord_ff;
      end
   end

   // Stage 5: count thresholds reached, pick the bin, sum the squares
   logic signed [63:0] y28, e1s, e2s, e3s;
   logic [6:0]         ge;
   logic [2:0]         cnt, bin_sel;
   logic               ay_pos;
   gobu_root_type      s5_ff, s5_in;

   always_comb begin
      y28    = {{4{s4_ay_ff[31]}}, s4_ay_ff, 28'd0};
      e1s    = {6'd0, s4_e1_ff};
      e2s    = {5'd0, s4_ax_ff, 28'd0};
      e3s    = {3'd0, s4_e3_ff};
      ge[0]  = y28 >= -e3s;
      ge[1]  = y28 >= -e2s;
      ge[2]  = y28 >= -e1s;
      ge[3]  = !y28[63];
      ge[4]  = y28 >= e1s;
      ge[5]  = y28 >= e2s;
      ge[6]  = y28 >= e3s;
      cnt    = 3'(ge[0]) + 3'(ge[1]) + 3'(ge[2]) + 3'(ge[3]) + 3'(ge[4])
             + 3'(ge[5]) + 3'(ge[6]);
      ay_pos = !s4_ay_ff[31] && (s4_ay_ff != '0);
      if ((s4_ax_ff == '0) && ay_pos) begin
         bin_sel = BIN_VERTICAL;
      end else begin
         bin_sel = cnt + BIN_OFFSET;
      end
      s5_in.res = '0;
      if (s4_bord_ff) begin
         s5_in.rem  = '0;
         s5_in.bin  = BIN_BORDER;
         s5_in.clip = 1'b0;
      end else begin
         s5_in.rem  = {1'b0, s4_sx2_ff} + {1'b0, s4_sy2_ff};
         s5_in.bin  = bin_sel;
         s5_in.clip = s4_clip_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s5_ff <= s5_in;
      end
   end

   assign dn_valid = vld_ff[NSTG-1];
   assign dn_data  = s5_ff;

   // A clip flag comes only with a component at a saturation bound
   a_clip_at_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] && s2_clip_ff |->
         (s2_dy_ff == SAT_POS) || (s2_dy_ff == SAT_NEG) ||
         (s2_dx_ff == SAT_POS) || (s2_dx_ff == SAT_NEG))
      else $error("clip flag without a saturated component");

   // A zero radicand is either a border pixel or a flat gradient
   a_zero_rad_bin: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NSTG-1] && (s5_ff.rem == '0) |->
         (s5_ff.bin == BIN_BORDER) || (s5_ff.bin == BIN_FLAT))
      else $error("unexpected bin for zero gradient");

endmodule

>>> rtl/core/gobu_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per item.
`timescale 1ns / 1ps
module gobu_sqrt_cell import gobu_pkg::*; #(
   parameter int unsigned STEP = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          up_valid,
   output logic          up_ready,
   input  gobu_root_type up_data,
   output logic          dn_valid,
   input  logic          dn_ready,
   output gobu_root_type dn_data
);

   localparam int unsigned SHIFT = RAD_W - 1 - 2 * STEP;
   localparam logic [RAD_W:0] TRIAL_BIT = {{RAD_W{1'b0}}, 1'b1} << SHIFT;

   logic          vld_ff;
   logic [RAD_W:0] trial;
   logic          take;
   gobu_root_type data_ff, data_in;

   assign up_ready = !vld_ff || dn_ready;

   // Trial subtract of this cell's root bit
   always_comb begin
      trial        = {1'b0, up_data.res} + TRIAL_BIT;
      take         = {1'b0, up_data.rem} >= trial;
      data_in      = up_data;
      if (take) begin
         data_in.rem = up_data.rem - trial[RAD_W-1:0];
         data_in.res = (up_data.res >> 1) + TRIAL_BIT[RAD_W-1:0];
      end else begin
         data_in.res = up_data.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (up_ready) begin
         vld_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = vld_ff;
   assign dn_data  = data_ff;

endmodule

>>> rtl/core/gradient_orientation_binner_unit.sv
// Top level of the gradient orientation binner: front end and square root chain.
`timescale 1ns / 1ps
//  channel  | dir | handshake       | payload
//  req_if   | in  | valid / ready   | pixel_above, pixel_below, pixel_left, pixel_right, on_border
//  rsp_if   | out | valid / ready   | orientation_bin, magnitude, clipped
//  csr      | in  | csr_wr_en       | csr_wr_data = inv_scale (Q8.24)
//
//  One request per cycle sustained while rsp_if accepts results; each result passes
//  through 6 front end stages plus 32 square root cells, one root bit per cell.
//  Reset clears every stage valid bit and returns inv_scale to 1.0.
//  Every stage holds its item while the next one is full and stalled; empty stages
//  keep filling, so requests are taken while a finished result waits on rsp_if.
module gradient_orientation_binner_unit import gobu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   gobu_req_if.sink    req_if,
   gobu_rsp_if.source  rsp_if,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic [31:0]   csr_scale_ff, csr_scale_in;
   gobu_pix_type  req_pix;
   gobu_root_type chain_data [ROOT_STEPS+1];
   logic          chain_vld  [ROOT_STEPS+1];
   logic          chain_rdy  [ROOT_STEPS+1];

   // Hold the scale register
   assign csr_scale_in = csr_wr_en ? csr_wr_data : csr_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_scale_ff <= INV_SCALE_RESET;
      end else begin
         csr_scale_ff <= csr_scale_in;
      end
   end

   // Gather the request payload
   always_comb begin
      req_pix.pixel_above = req_if.pixel_above;
      req_pix.pixel_below = req_if.pixel_below;
      req_pix.pixel_left  = req_if.pixel_left;
      req_pix.pixel_right = req_if.pixel_right;
      req_pix.on_border   = req_if.on_border;
   end

   gobu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .inv_scale (csr_scale_ff),
      .up_valid  (req_if.valid),
      .up_ready  (req_if.ready),
      .up_data   (req_pix),
      .dn_valid  (chain_vld[0]),
      .dn_ready  (chain_rdy[0]),
      .dn_data   (chain_data[0])
   );

   // Square root chain, most significant root bit first
   for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_cell
      gobu_sqrt_cell #(
         .STEP (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (chain_vld[g]),
         .up_ready (chain_rdy[g]),
         .up_data  (chain_data[g]),
         .dn_valid (chain_vld[g+1]),
         .dn_ready (chain_rdy[g+1]),
         .dn_data  (chain_data[g+1])
      );
   end

   // Drive the response from the last cell
   assign chain_rdy[ROOT_STEPS]  = rsp_if.ready;
   assign rsp_if.valid           = chain_vld[ROOT_STEPS];
   assign rsp_if.orientation_bin = chain_data[ROOT_STEPS].bin;
   assign rsp_if.magnitude       = chain_data[ROOT_STEPS].res[31:0];
   assign rsp_if.clipped         = chain_data[ROOT_STEPS].clip;

   // Floor square root leaves a remainder of at most twice the root
   a_root_remainder: assert property (@(posedge clock) disable iff (reset)
      chain_vld[ROOT_STEPS] |->
         ({1'b0, chain_data[ROOT_STEPS].rem} <= {chain_data[ROOT_STEPS].res, 1'b0}))
      else $error("square root remainder out of range");

endmodule
